// ===== hdl/keyframe_tween_engine_defines.svh =====
// assertion macros used by the checker file
`ifndef KEYFRAME_TWEEN_ENGINE_DEFINES_SVH
`define KEYFRAME_TWEEN_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define KTE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("kte check failed");

// next-cycle implication, disabled during reset
`define KTE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("kte check failed");

// next-cycle implication that also holds through reset
`define KTE_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("kte check failed");

`endif

// ===== hdl/kte_pkg.sv =====
`timescale 1ns / 1ps
package kte_pkg;

    localparam int MAX_KEYS  = 8;
    localparam int FRAC_BITS = 16;

    localparam int KEY_IDX_W = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KEY_CNT_W = $clog2(MAX_KEYS + 1);

    localparam int POS_W     = 17;
    localparam int POS_FRAC  = 16;
    localparam int LEVEL_W   = 32;
    localparam int DUR_W     = 16;
    localparam int TICK_W    = 8;
    localparam int LOOP_W    = 16;
    localparam int ELAPSED_W = 17;
    localparam int ENTRY_W   = POS_W + LEVEL_W;

    localparam int Q_W       = FRAC_BITS + 1;
    // position times duration, position never above one
    localparam int PROD_W    = POS_FRAC + DUR_W;
    localparam int NUM_W     = ELAPSED_W + POS_FRAC + 1;
    localparam int DIV_W     = PROD_W;
    localparam int DCNT_W    = $clog2(FRAC_BITS + 1);
    localparam int STEPS_MAX = (Q_W > DUR_W) ? Q_W : DUR_W;
    localparam int MCNT_W    = $clog2(STEPS_MAX + 1);

    localparam int ACC_W     = LEVEL_W + 1 + Q_W + 1;
    localparam int CH_W      = 8;
    localparam int NUM_CH    = 3;
    localparam int CACC_W    = CH_W + 1 + Q_W;

    localparam logic [Q_W-1:0]   Q_ONE   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [POS_W-1:0] POS_ONE = {1'b1, {POS_FRAC{1'b0}}};

    localparam logic [1:0] FUNC_START = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_KEY   = 2'd2;

    localparam int APB_W     = 32;
    localparam int PADDR_W   = 5;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_DURATION    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_TICK        = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LOOP_LIMIT  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_START_LEVEL = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_END_LEVEL   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_COLOR_MODE  = 3'd5;

    localparam logic [DUR_W-1:0]  DURATION_RST   = 16'd0;
    localparam logic [TICK_W-1:0] TICK_RST       = 8'd16;
    localparam logic [LOOP_W-1:0] LOOP_LIMIT_RST = 16'd1;
    localparam logic [LOOP_W-1:0] LOOP_FOREVER   = 16'hFFFF;

    typedef struct packed {
        logic [1:0]                func;
        logic [POS_W-1:0]          key_position;
        logic signed [LEVEL_W-1:0] key_level;
    } t_in_item;

    typedef struct packed {
        logic signed [LEVEL_W-1:0] level;
        logic                      done_res;
        logic                      wrapped;
    } t_out_item;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic done;
    } t_div_sts;

endpackage

// ===== hdl/kte_in_if.sv =====
`timescale 1ns / 1ps
interface kte_in_if;
    logic              valid;
    logic              ready;
    kte_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/kte_out_if.sv =====
`timescale 1ns / 1ps
interface kte_out_if;
    logic               valid;
    logic               ready;
    kte_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/kte_ram.sv =====
`timescale 1ns / 1ps
module kte_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 8,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/kte_div.sv =====
`timescale 1ns / 1ps
module kte_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  kte_pkg::t_div_ctl             i_ctl,
    input  logic [kte_pkg::DIV_W-1:0]     i_num,
    input  logic [kte_pkg::DIV_W-1:0]     i_den,
    output kte_pkg::t_div_sts             o_sts,
    output logic [kte_pkg::FRAC_BITS-1:0] o_quot
);

    logic [kte_pkg::DIV_W-1:0]     r_rem;
    logic [kte_pkg::DIV_W-1:0]     r_den;
    logic [kte_pkg::FRAC_BITS-1:0] r_quot;
    logic [kte_pkg::DCNT_W-1:0]    r_cnt;
    logic                          r_busy;
    logic                          r_done;

    logic [kte_pkg::DIV_W:0]       w_shift;
    logic [kte_pkg::DIV_W+1:0]     w_diff;

    // remainder stays below the divisor, one quotient bit per cycle
    assign w_shift = {r_rem, 1'b0};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= kte_pkg::DCNT_W'(kte_pkg::FRAC_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - kte_pkg::DCNT_W'(1);
                if (r_cnt == kte_pkg::DCNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_num;
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            if (!w_diff[kte_pkg::DIV_W+1]) begin
                r_rem  <= w_diff[kte_pkg::DIV_W-1:0];
                r_quot <= {r_quot[kte_pkg::FRAC_BITS-2:0], 1'b1};
            end else begin
                r_rem  <= w_shift[kte_pkg::DIV_W-1:0];
                r_quot <= {r_quot[kte_pkg::FRAC_BITS-2:0], 1'b0};
            end
        end
    end

    assign o_sts.done = r_done;
    assign o_quot     = r_quot;

endmodule

// ===== hdl/keyframe_tween_engine.sv =====
`timescale 1ns / 1ps
// a tick reads the lower and upper keys, forms the shift-add position products and the segment
// ratio, which uses the 16-step divider when it lies strictly between zero and one, then runs
// the shift-add interpolation product and loads the output register once the output is free
// throughput: one tick in flight at a time, the next item is taken once the result is loaded
// reset is synchronous: running state, counters and configuration registers go to their defaults,
// the keyframe store and the per-tick work registers are not cleared
module keyframe_tween_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    kte_in_if.sink                        i_in,
    kte_out_if.source                     o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kte_pkg::PADDR_W-1:0]   paddr,
    input  logic [kte_pkg::APB_W-1:0]     pwdata,
    output logic [kte_pkg::APB_W-1:0]     prdata,
    output logic                          pready
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD_LO,
        S_RD_HI,
        S_LOAD_HI,
        S_MUL_POS,
        S_RATIO,
        S_DIV,
        S_LERP_INIT,
        S_MUL_Q,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [kte_pkg::DUR_W-1:0]          r_duration;
    logic [kte_pkg::TICK_W-1:0]         r_tick;
    logic [kte_pkg::LOOP_W-1:0]         r_loop_limit;
    logic signed [kte_pkg::LEVEL_W-1:0] r_start_level;
    logic signed [kte_pkg::LEVEL_W-1:0] r_end_level;
    logic                               r_color_mode;

    // animation state
    logic [kte_pkg::ELAPSED_W-1:0]      r_elapsed;
    logic [kte_pkg::LOOP_W-1:0]         r_loop_index;
    logic [kte_pkg::KEY_CNT_W-1:0]      r_target;
    logic [kte_pkg::KEY_CNT_W-1:0]      r_key_count;
    logic                               r_running;

    logic                               r_out_valid;
    kte_pkg::t_out_item                 r_out_data;

    // per-tick work registers
    logic [kte_pkg::KEY_CNT_W-1:0]      r_t;
    logic [kte_pkg::PROD_W-1:0]         r_lo_m;
    logic [kte_pkg::PROD_W-1:0]         r_hi_m;
    logic [kte_pkg::PROD_W-1:0]         r_lo_acc;
    logic [kte_pkg::PROD_W-1:0]         r_hi_acc;
    logic [kte_pkg::DUR_W-1:0]          r_dsh;
    logic [kte_pkg::MCNT_W-1:0]         r_cnt;
    logic signed [kte_pkg::LEVEL_W-1:0] r_a;
    logic signed [kte_pkg::LEVEL_W-1:0] r_b;
    logic [kte_pkg::Q_W-1:0]            r_q;
    logic [kte_pkg::Q_W-1:0]            r_qsh;
    logic signed [kte_pkg::ACC_W-1:0]   r_m;
    logic signed [kte_pkg::ACC_W-1:0]   r_acc;
    logic signed [kte_pkg::CACC_W-1:0]  r_cm   [kte_pkg::NUM_CH];
    logic signed [kte_pkg::CACC_W-1:0]  r_cacc [kte_pkg::NUM_CH];

    logic                               w_accept;
    logic                               w_cfg_we;
    logic [kte_pkg::REG_IDX_W-1:0]      w_reg_idx;
    logic                               w_key_ok;
    logic                               w_ram_we;
    logic [kte_pkg::KEY_IDX_W-1:0]      w_raddr;
    logic [kte_pkg::KEY_CNT_W-1:0]      w_t_m1;
    logic [kte_pkg::KEY_CNT_W-1:0]      w_t_sel;
    logic [kte_pkg::ENTRY_W-1:0]        w_rdata;
    logic [kte_pkg::POS_W-1:0]          w_rd_pos;
    logic signed [kte_pkg::LEVEL_W-1:0] w_rd_lvl;
    logic                               w_t_pos;
    logic                               w_t_inner;

    logic signed [kte_pkg::NUM_W-1:0]   w_num;
    logic signed [kte_pkg::NUM_W-1:0]   w_den;
    kte_pkg::t_div_ctl                  w_div_ctl;
    kte_pkg::t_div_sts                  w_div_sts;
    logic [kte_pkg::FRAC_BITS-1:0]      w_quot;

    logic signed [kte_pkg::LEVEL_W:0]   w_diff;
    logic signed [kte_pkg::ACC_W-1:0]   w_tq;
    logic signed [kte_pkg::ACC_W-1:0]   w_v;
    logic signed [kte_pkg::ACC_W-1:0]   w_b_ext;
    logic signed [kte_pkg::ACC_W-1:0]   w_clamp;
    logic                               w_rnd;
    logic [kte_pkg::LEVEL_W-1:0]        w_rgb;

    logic                               w_out_free;
    logic                               w_at_end;
    logic [kte_pkg::LOOP_W-1:0]         n_loop_index;
    logic                               w_finish;
    logic [kte_pkg::KEY_CNT_W-1:0]      n_target;
    logic [kte_pkg::ELAPSED_W-1:0]      n_elapsed;
    logic signed [kte_pkg::LEVEL_W-1:0] n_level;

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;
    assign w_out_free  = !r_out_valid || o_out.ready;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[kte_pkg::PADDR_W-1:2];
    assign w_cfg_we  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_reg_idx)
            kte_pkg::REG_DURATION:    prdata = kte_pkg::APB_W'(r_duration);
            kte_pkg::REG_TICK:        prdata = kte_pkg::APB_W'(r_tick);
            kte_pkg::REG_LOOP_LIMIT:  prdata = kte_pkg::APB_W'($signed(r_loop_limit));
            kte_pkg::REG_START_LEVEL: prdata = r_start_level;
            kte_pkg::REG_END_LEVEL:   prdata = r_end_level;
            kte_pkg::REG_COLOR_MODE:  prdata = kte_pkg::APB_W'(r_color_mode);
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration    <= kte_pkg::DURATION_RST;
            r_tick        <= kte_pkg::TICK_RST;
            r_loop_limit  <= kte_pkg::LOOP_LIMIT_RST;
            r_start_level <= '0;
            r_end_level   <= '0;
            r_color_mode  <= 1'b0;
        end else if (w_cfg_we) begin
            unique case (w_reg_idx)
                kte_pkg::REG_DURATION:    r_duration    <= pwdata[kte_pkg::DUR_W-1:0];
                kte_pkg::REG_TICK:        r_tick        <= pwdata[kte_pkg::TICK_W-1:0];
                kte_pkg::REG_LOOP_LIMIT:  r_loop_limit  <= pwdata[kte_pkg::LOOP_W-1:0];
                kte_pkg::REG_START_LEVEL: r_start_level <= pwdata;
                kte_pkg::REG_END_LEVEL:   r_end_level   <= pwdata;
                kte_pkg::REG_COLOR_MODE:  r_color_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    // keyframe store
    assign w_key_ok = (i_in.data.key_position != '0)
                   && (i_in.data.key_position < kte_pkg::POS_ONE)
                   && (r_key_count < kte_pkg::KEY_CNT_W'(kte_pkg::MAX_KEYS));
    assign w_ram_we = w_accept && (i_in.data.func == kte_pkg::FUNC_KEY) && w_key_ok;
    assign w_t_m1   = r_t - kte_pkg::KEY_CNT_W'(1);
    assign w_raddr  = (r_state == S_RD_LO) ? w_t_m1[kte_pkg::KEY_IDX_W-1:0]
                                           : r_t[kte_pkg::KEY_IDX_W-1:0];
    assign w_t_sel  = (r_target > r_key_count) ? r_key_count : r_target;

    kte_ram #(
        .WIDTH (kte_pkg::ENTRY_W),
        .DEPTH (kte_pkg::MAX_KEYS)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_key_count[kte_pkg::KEY_IDX_W-1:0]),
        .i_wdata ({i_in.data.key_position, i_in.data.key_level}),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_pos  = w_rdata[kte_pkg::ENTRY_W-1 -: kte_pkg::POS_W];
    assign w_rd_lvl  = w_rdata[kte_pkg::LEVEL_W-1:0];
    assign w_t_pos   = (r_t != '0);
    assign w_t_inner = (r_t < r_key_count);

    // segment ratio
    assign w_num = {1'b0, r_elapsed, {kte_pkg::POS_FRAC{1'b0}}} - {2'b00, r_lo_acc};
    assign w_den = {2'b00, r_hi_acc} - {2'b00, r_lo_acc};

    assign w_div_ctl.start = (r_state == S_RATIO) && (w_den > 0) && (w_num > 0)
                          && (w_num < w_den);

    kte_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_div_ctl),
        .i_num   (w_num[kte_pkg::DIV_W-1:0]),
        .i_den   (w_den[kte_pkg::DIV_W-1:0]),
        .o_sts   (w_div_sts),
        .o_quot  (w_quot)
    );

    // scalar finish: truncate toward zero, clamp toward end
    assign w_diff  = {r_b[kte_pkg::LEVEL_W-1], r_b} - {r_a[kte_pkg::LEVEL_W-1], r_a};
    assign w_tq    = r_acc >>> kte_pkg::FRAC_BITS;
    assign w_rnd   = r_acc[kte_pkg::ACC_W-1] && (r_acc[kte_pkg::FRAC_BITS-1:0] != '0);
    assign w_v     = w_tq + $signed({{(kte_pkg::ACC_W-1){1'b0}}, w_rnd});
    assign w_b_ext = {{(kte_pkg::ACC_W-kte_pkg::LEVEL_W){r_b[kte_pkg::LEVEL_W-1]}}, r_b};

    always_comb begin
        w_clamp = w_v;
        if (r_a > r_b) begin
            if (w_v < w_b_ext) begin
                w_clamp = w_b_ext;
            end
        end else if (w_v > w_b_ext) begin
            w_clamp = w_b_ext;
        end
    end

    // per-channel finish
    always_comb begin
        logic signed [kte_pkg::CACC_W-1:0] v_cq;
        logic                              v_crnd;
        w_rgb = '0;
        for (int ch = 0; ch < kte_pkg::NUM_CH; ch++) begin
            v_cq   = r_cacc[ch] >>> kte_pkg::FRAC_BITS;
            v_crnd = r_cacc[ch][kte_pkg::CACC_W-1]
                  && (r_cacc[ch][kte_pkg::FRAC_BITS-1:0] != '0);
            w_rgb[kte_pkg::CH_W*ch +: kte_pkg::CH_W] =
                r_a[kte_pkg::CH_W*ch +: kte_pkg::CH_W] + v_cq[kte_pkg::CH_W-1:0]
                + kte_pkg::CH_W'(v_crnd);
        end
    end

    assign n_level = r_color_mode ? $signed(w_rgb) : w_clamp[kte_pkg::LEVEL_W-1:0];

    // end of pass
    assign w_at_end     = (r_elapsed >= {1'b0, r_duration});
    assign n_loop_index = (r_loop_index != '1) ? r_loop_index + kte_pkg::LOOP_W'(1)
                                               : r_loop_index;
    assign w_finish     = (r_loop_limit != kte_pkg::LOOP_FOREVER)
                       && ($signed({1'b0, n_loop_index})
                           >= $signed({r_loop_limit[kte_pkg::LOOP_W-1], r_loop_limit}));
    assign n_target     = ((r_q == kte_pkg::Q_ONE) && w_t_inner)
                        ? r_t + kte_pkg::KEY_CNT_W'(1) : r_t;
    assign n_elapsed    = r_elapsed + kte_pkg::ELAPSED_W'(r_tick);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_elapsed    <= '0;
            r_loop_index <= '0;
            r_target     <= '0;
            r_key_count  <= '0;
            r_running    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        case (i_in.data.func)
                            kte_pkg::FUNC_START: begin
                                r_elapsed    <= '0;
                                r_loop_index <= '0;
                                r_target     <= '0;
                                r_running    <= 1'b1;
                            end
                            kte_pkg::FUNC_KEY: begin
                                if (w_key_ok) begin
                                    r_key_count <= r_key_count + kte_pkg::KEY_CNT_W'(1);
                                end
                            end
                            kte_pkg::FUNC_TICK: begin
                                if (r_running) begin
                                    r_state <= S_RD_LO;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD_LO:   r_state <= S_RD_HI;
                S_RD_HI:   r_state <= S_LOAD_HI;
                S_LOAD_HI: r_state <= S_MUL_POS;
                S_MUL_POS: begin
                    if (r_cnt == kte_pkg::MCNT_W'(1)) begin
                        r_state <= S_RATIO;
                    end
                end
                S_RATIO: begin
                    r_state <= w_div_ctl.start ? S_DIV : S_LERP_INIT;
                end
                S_DIV: begin
                    if (w_div_sts.done) begin
                        r_state <= S_LERP_INIT;
                    end
                end
                S_LERP_INIT: r_state <= S_MUL_Q;
                S_MUL_Q: begin
                    if (r_cnt == kte_pkg::MCNT_W'(1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_valid      <= 1'b1;
                        r_out_data.level <= n_level;
                        r_state          <= S_IDLE;
                        if (w_at_end) begin
                            r_loop_index <= n_loop_index;
                            if (w_finish) begin
                                r_running           <= 1'b0;
                                r_elapsed           <= n_elapsed;
                                r_target            <= n_target;
                                r_out_data.done_res <= 1'b1;
                                r_out_data.wrapped  <= 1'b0;
                            end else begin
                                r_elapsed           <= '0;
                                r_target            <= '0;
                                r_out_data.done_res <= 1'b0;
                                r_out_data.wrapped  <= 1'b1;
                            end
                        end else begin
                            r_elapsed           <= n_elapsed;
                            r_target            <= n_target;
                            r_out_data.done_res <= 1'b0;
                            r_out_data.wrapped  <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath: serial products and ratio
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_t <= w_t_sel;
            end
            S_RD_HI: begin
                r_lo_m <= w_t_pos ? kte_pkg::PROD_W'(w_rd_pos) : '0;
                r_a    <= w_t_pos ? w_rd_lvl : r_start_level;
            end
            S_LOAD_HI: begin
                r_hi_m   <= w_t_inner ? kte_pkg::PROD_W'(w_rd_pos)
                                      : kte_pkg::PROD_W'(kte_pkg::POS_ONE);
                r_b      <= w_t_inner ? w_rd_lvl : r_end_level;
                r_dsh    <= r_duration;
                r_lo_acc <= '0;
                r_hi_acc <= '0;
                r_cnt    <= kte_pkg::MCNT_W'(kte_pkg::DUR_W);
            end
            S_MUL_POS: begin
                if (r_dsh[0]) begin
                    r_lo_acc <= r_lo_acc + r_lo_m;
                    r_hi_acc <= r_hi_acc + r_hi_m;
                end
                r_lo_m <= {r_lo_m[kte_pkg::PROD_W-2:0], 1'b0};
                r_hi_m <= {r_hi_m[kte_pkg::PROD_W-2:0], 1'b0};
                r_dsh  <= {1'b0, r_dsh[kte_pkg::DUR_W-1:1]};
                r_cnt  <= r_cnt - kte_pkg::MCNT_W'(1);
            end
            S_RATIO: begin
                // zero or negative segment length counts as complete
                if (w_den <= 0) begin
                    r_q <= kte_pkg::Q_ONE;
                end else if (w_num <= 0) begin
                    r_q <= '0;
                end else begin
                    r_q <= kte_pkg::Q_ONE;
                end
            end
            S_DIV: begin
                if (w_div_sts.done) begin
                    r_q <= {1'b0, w_quot};
                end
            end
            S_LERP_INIT: begin
                r_qsh <= r_q;
                r_m   <= {{(kte_pkg::ACC_W-kte_pkg::LEVEL_W-1){w_diff[kte_pkg::LEVEL_W]}},
                          w_diff};
                r_acc <= {{(kte_pkg::ACC_W-kte_pkg::LEVEL_W-kte_pkg::FRAC_BITS)
                           {r_a[kte_pkg::LEVEL_W-1]}}, r_a, {kte_pkg::FRAC_BITS{1'b0}}};
                for (int ch = 0; ch < kte_pkg::NUM_CH; ch++) begin
                    r_cm[ch]   <= kte_pkg::CACC_W'(
                        $signed({1'b0, r_b[kte_pkg::CH_W*ch +: kte_pkg::CH_W]})
                        - $signed({1'b0, r_a[kte_pkg::CH_W*ch +: kte_pkg::CH_W]}));
                    r_cacc[ch] <= '0;
                end
                r_cnt <= kte_pkg::MCNT_W'(kte_pkg::Q_W);
            end
            S_MUL_Q: begin
                if (r_qsh[0]) begin
                    r_acc <= r_acc + r_m;
                    for (int ch = 0; ch < kte_pkg::NUM_CH; ch++) begin
                        r_cacc[ch] <= r_cacc[ch] + r_cm[ch];
                    end
                end
                r_m <= r_m <<< 1;
                for (int ch = 0; ch < kte_pkg::NUM_CH; ch++) begin
                    r_cm[ch] <= r_cm[ch] <<< 1;
                end
                r_qsh <= {1'b0, r_qsh[kte_pkg::Q_W-1:1]};
                r_cnt <= r_cnt - kte_pkg::MCNT_W'(1);
            end
            default: ;
        endcase
    end

endmodule

// ===== hdl/kte_checker.sv =====
`timescale 1ns / 1ps
`include "keyframe_tween_engine_defines.svh"
module kte_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input kte_pkg::t_out_item i_out_data
);

    // a stalled result holds
    `KTE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_data))

    // a new result comes with the input side open again
    `KTE_ASSERT_IMP(a_rose_ready, i_clk, i_rst_n, $rose(i_out_valid), i_in_ready)

    // a pass either finishes or wraps, never both
    `KTE_ASSERT_IMP(a_done_wrap, i_clk, i_rst_n, i_out_valid, !(i_out_data.done_res && i_out_data.wrapped))

    // reset drops any pending result
    `KTE_ASSERT_NXT_ALWAYS(a_rst_clear, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind keyframe_tween_engine kte_checker u_kte_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
